// File: rtl/histogram_percentile_threshold_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the percentile threshold block
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_PERCENTILE_THRESHOLD_MACROS_SVH
`define HISTOGRAM_PERCENTILE_THRESHOLD_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HPT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/hpt_pkg.sv
// ----------------------------------------------------------------------------
// Percentile threshold package
// Widths, codes and the sequencer state type of the percentile threshold block.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

	localparam int FRAME_WIDTH_DEF  = 320;
	localparam int FRAME_HEIGHT_DEF = 240;

	localparam int LUMA_W  = 8;
	localparam int PCT_W   = 7;
	localparam int CNT_W   = 17;
	localparam int BINS    = 256;
	localparam int RUN_W   = 32;

	localparam logic [PCT_W-1:0]  PCT_RESET  = 7'd90;
	localparam logic [LUMA_W-1:0] LUMA_MAX   = 8'd255;
	localparam logic [LUMA_W-1:0] LAST_BIN   = 8'd254;

	localparam logic OP_ACCUM    = 1'b0;
	localparam logic OP_BINARIZE = 1'b1;

	localparam logic RK_PIXELS    = 1'b0;
	localparam logic RK_THRESHOLD = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR_EVEN,
		ST_WR_ODD,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// File: rtl/histogram_percentile_threshold.sv
// ----------------------------------------------------------------------------
// Histogram percentile threshold binariser
// Counts luma pairs into a 256-bin histogram held in a synchronous memory,
// finds the percentile bin at frame end and binarises luma against it.
//
// Channel   Dir  Width  Contents
// s_*       in   16+2   tdata luma_even, luma_odd; tuser op; tlast frame_end
// m_*       out  24+1   tdata bin_even, bin_odd, threshold_out; tuser kind
// cfg_*     in   7      percent_tune, written when cfg_wr_en is high
//
// A binarise word is binarised as it is taken and registered for output; an
// accumulate word takes one read and two write-backs through the single write
// port of the memory. A frame-end accumulate word adds the bin scan: 255 reads
// at one a cycle, a drain of the scan pipeline, then the threshold word emit.
// Reset clears per-bin valid bits at once, so no clearing pass is needed.
// Input words are taken only while the sequencer is idle and the output
// register is empty or being read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "histogram_percentile_threshold_macros.svh"

module histogram_percentile_threshold #(
	parameter int FRAME_WIDTH  = hpt_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = hpt_pkg::FRAME_HEIGHT_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [hpt_pkg::PCT_W-1:0] cfg_wr_data,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [15:0]              s_tdata,  // luma_even, luma_odd
	input  wire logic                     s_tuser,  // op
	input  wire logic                     s_tlast,  // frame_end
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [23:0]                   m_tdata,  // bin_even, bin_odd, threshold_out
	output logic                          m_tuser   // result_kind
);

	localparam int CNT_W = hpt_pkg::CNT_W;
	localparam int LW    = hpt_pkg::LUMA_W;
	localparam int PIX   = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int PIX_W = $clog2(PIX + 1);
	localparam int TGT_W = PIX_W + hpt_pkg::PCT_W;
	localparam int CMP_W = (TGT_W > hpt_pkg::RUN_W) ? TGT_W : hpt_pkg::RUN_W;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
	endfunction

	hpt_pkg::state_t state_q, state_d;

	logic [hpt_pkg::PCT_W-1:0] pct_q;
	logic [TGT_W-1:0]          tgt_q;
	logic [LW-1:0]             cur_thr_q;
	logic [LW-1:0]             even_q, odd_q;
	logic                      fe_q;
	logic [LW-1:0]             scan_q;

	logic [CNT_W-1:0] mem [hpt_pkg::BINS];
	logic [hpt_pkg::BINS-1:0] valid_q;
	logic [CNT_W-1:0] rd_a_s1, rd_b_s1;
	logic             val_a_s1, val_b_s1;

	logic                      scan_vld_s1, scan_vld_s2;
	logic [LW-1:0]             scan_bin_s1, scan_bin_s2;
	logic [hpt_pkg::RUN_W-1:0] cnt100_s2;
	logic [hpt_pkg::RUN_W-1:0] running_q;
	logic                      found_q;
	logic [LW-1:0]             thr_scan_q;

	logic             m_valid_q;
	logic [23:0]      m_data_q;
	logic             m_user_q;

	logic             out_free, in_accept, acc_accept, bin_accept;
	logic             mem_we, rd_en, scan_issue, scan_start, emit_load, clear_valid;
	logic [LW-1:0]    waddr, rd_addr_a, rd_addr_b;
	logic [CNT_W-1:0] wdata;
	logic [CNT_W-1:0] cnt_a, cnt_b, new_e, new_o;
	logic [hpt_pkg::RUN_W-1:0] cnt_ext, run_sum;
	logic             hit;
	logic [LW-1:0]    bin_e, bin_o;

	assign out_free   = !m_valid_q || m_tready;
	assign s_tready   = (state_q == hpt_pkg::ST_IDLE) && out_free;
	assign in_accept  = s_tvalid && s_tready;
	assign acc_accept = in_accept && (s_tuser == hpt_pkg::OP_ACCUM);
	assign bin_accept = in_accept && (s_tuser == hpt_pkg::OP_BINARIZE);

	assign cnt_a = val_a_s1 ? rd_a_s1 : '0;
	assign cnt_b = val_b_s1 ? rd_b_s1 : '0;
	assign new_e = sat_inc(cnt_a);
	assign new_o = (even_q == odd_q) ? sat_inc(new_e) : sat_inc(cnt_b);

	assign cnt_ext = hpt_pkg::RUN_W'(cnt_a);
	assign run_sum = running_q + cnt100_s2;
	assign hit     = scan_vld_s2 && !found_q && (CMP_W'(run_sum) > CMP_W'(tgt_q));

	assign bin_e = (s_tdata[7:0]  < cur_thr_q) ? '0 : hpt_pkg::LUMA_MAX;
	assign bin_o = (s_tdata[15:8] < cur_thr_q) ? '0 : hpt_pkg::LUMA_MAX;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hpt_pkg::ST_IDLE: begin
				if (acc_accept) begin
					state_d = hpt_pkg::ST_WR_EVEN;
				end
			end
			hpt_pkg::ST_WR_EVEN: state_d = hpt_pkg::ST_WR_ODD;
			hpt_pkg::ST_WR_ODD: begin
				state_d = fe_q ? hpt_pkg::ST_SCAN : hpt_pkg::ST_IDLE;
			end
			hpt_pkg::ST_SCAN: begin
				if (scan_q == hpt_pkg::LAST_BIN) begin
					state_d = hpt_pkg::ST_DRAIN;
				end
			end
			hpt_pkg::ST_DRAIN: begin
				if (!scan_vld_s1 && !scan_vld_s2) begin
					state_d = hpt_pkg::ST_EMIT;
				end
			end
			hpt_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = hpt_pkg::ST_IDLE;
				end
			end
			default: state_d = hpt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we      = 1'b0;
		waddr       = even_q;
		wdata       = new_e;
		rd_en       = 1'b0;
		rd_addr_a   = s_tdata[7:0];
		rd_addr_b   = s_tdata[15:8];
		scan_issue  = 1'b0;
		scan_start  = 1'b0;
		emit_load   = 1'b0;
		clear_valid = 1'b0;
		case (state_q)
			hpt_pkg::ST_IDLE: rd_en = acc_accept;
			hpt_pkg::ST_WR_EVEN: mem_we = 1'b1;
			hpt_pkg::ST_WR_ODD: begin
				mem_we     = 1'b1;
				waddr      = odd_q;
				wdata      = new_o;
				scan_start = fe_q;
			end
			hpt_pkg::ST_SCAN: begin
				rd_en      = 1'b1;
				rd_addr_a  = scan_q;
				rd_addr_b  = scan_q;
				scan_issue = 1'b1;
			end
			hpt_pkg::ST_DRAIN: ;
			hpt_pkg::ST_EMIT: begin
				emit_load   = out_free;
				clear_valid = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hpt_pkg::ST_IDLE;
			pct_q       <= hpt_pkg::PCT_RESET;
			cur_thr_q   <= hpt_pkg::LUMA_MAX;
			valid_q     <= '0;
			scan_vld_s1 <= 1'b0;
			scan_vld_s2 <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= scan_issue;
			scan_vld_s2 <= scan_vld_s1;
			if (cfg_wr_en) begin
				pct_q <= cfg_wr_data;
			end
			if (emit_load) begin
				cur_thr_q <= thr_scan_q;
			end
			if (clear_valid) begin
				valid_q <= '0;
			end else if (mem_we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (bin_accept || emit_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_a_s1  <= mem[rd_addr_a];
			rd_b_s1  <= mem[rd_addr_b];
			val_a_s1 <= valid_q[rd_addr_a];
			val_b_s1 <= valid_q[rd_addr_b];
		end
	end

	always_ff @(posedge clk) begin
		tgt_q <= TGT_W'(PIX) * TGT_W'(pct_q);
		if (acc_accept) begin
			even_q <= s_tdata[7:0];
			odd_q  <= s_tdata[15:8];
			fe_q   <= s_tlast;
		end
		if (scan_start) begin
			scan_q <= '0;
		end else if (scan_issue) begin
			scan_q <= scan_q + LW'(1);
		end
		scan_bin_s1 <= scan_q;
		scan_bin_s2 <= scan_bin_s1;
		cnt100_s2   <= (cnt_ext << 6) + (cnt_ext << 5) + (cnt_ext << 2);
		if (scan_start) begin
			running_q  <= '0;
			found_q    <= 1'b0;
			thr_scan_q <= hpt_pkg::LUMA_MAX;
		end else if (scan_vld_s2) begin
			running_q <= run_sum;
			if (hit) begin
				found_q    <= 1'b1;
				thr_scan_q <= scan_bin_s2;
			end
		end
		if (bin_accept) begin
			m_data_q <= {8'd0, bin_o, bin_e};
			m_user_q <= hpt_pkg::RK_PIXELS;
		end else if (emit_load) begin
			m_data_q <= {thr_scan_q, 16'd0};
			m_user_q <= hpt_pkg::RK_THRESHOLD;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	`HPT_ASSERT_SAME(a_we_in_write, mem_we,
		(state_q == hpt_pkg::ST_WR_EVEN) || (state_q == hpt_pkg::ST_WR_ODD),
		"Histogram written outside a write-back state.")
	`HPT_ASSERT_SAME(a_idle_pipe_empty, state_q == hpt_pkg::ST_IDLE,
		!scan_vld_s1 && !scan_vld_s2, "Scan pipeline busy while idle.")
	`HPT_ASSERT_NEXT(a_emit_clears, (state_q == hpt_pkg::ST_EMIT) && out_free,
		valid_q == '0, "Histogram not cleared after threshold word.")
	`HPT_ASSERT_SAME(a_thr_word_shape, m_valid_q && (m_user_q == hpt_pkg::RK_THRESHOLD),
		m_data_q[15:0] == 16'd0, "Threshold word carries pixel data.")

endmodule

`default_nettype wire
